>>> rtl/srfr_pkg.sv
// Shared types and constants for the servo response frame receiver.
// Used by every module under rtl/; no dependencies of its own.
`timescale 1ns / 1ps
package srfr_pkg;
	localparam int MAX_LEN     = 32;
	localparam int STORE_DEPTH = MAX_LEN + 1;
	localparam int IDX_W       = $clog2(STORE_DEPTH);
	localparam int MEM_DEPTH   = 2 * STORE_DEPTH;
	localparam int ADDR_W      = $clog2(MEM_DEPTH);
	localparam int QDEPTH      = 2;
	localparam int QPTR_W      = $clog2(QDEPTH);
	localparam int QCNT_W      = $clog2(QDEPTH + 1);

	localparam logic [7:0] HDR_BYTE = 8'h55;
	localparam logic [7:0] MIN_LEN  = 8'd2;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_CSUM = 2'd1;
	localparam logic [1:0] ST_LEN  = 2'd2;

	// One unit of work handed from the front to the back.
	typedef struct packed {
		logic [1:0]       status;
		logic             bank;
		logic [IDX_W-1:0] last_idx;
	} job_t;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		logic [7:0]        data;
	} mem_wr_t;

	typedef struct packed {
		logic en;
		logic bank;
	} busy_clr_t;

	function automatic logic [ADDR_W-1:0] mem_addr(input logic bank,
			input logic [IDX_W-1:0] idx);
		mem_addr = bank ? (ADDR_W'(STORE_DEPTH) + ADDR_W'(idx)) : ADDR_W'(idx);
	endfunction
endpackage

>>> rtl/srfr_buf.sv
// Two-bank frame byte store: one write port, one registered read port.
// Depends on srfr_pkg.
`timescale 1ns / 1ps
module srfr_buf (
	input  logic                      clk,
	input  srfr_pkg::mem_wr_t         wr,
	input  logic                      rd_en,
	input  logic [srfr_pkg::ADDR_W-1:0] rd_addr,
	output logic [7:0]                rd_data
);
	import srfr_pkg::*;

	logic [7:0] mem [MEM_DEPTH];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end
endmodule

>>> rtl/srfr_fifo.sv
// Short job queue between the receive front end and the emit back end.
// Depends on srfr_pkg.
`timescale 1ns / 1ps
module srfr_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  srfr_pkg::job_t push_job,
	output logic           full,
	input  logic           pop,
	output logic           head_valid,
	output srfr_pkg::job_t head_job
);
	import srfr_pkg::*;

	job_t              slot_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;

	assign full       = (cnt_q == QCNT_W'(QDEPTH));
	assign head_valid = (cnt_q != '0);
	assign head_job   = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end
endmodule

>>> rtl/srfr_front.sv
// Receive front end: header hunt, length check, byte store, checksum.
// Pushes one job per finished frame or error. Depends on srfr_pkg.
`timescale 1ns / 1ps
module srfr_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [7:0]          rx_byte,
	output srfr_pkg::mem_wr_t   mem_wr,
	output logic                push,
	output srfr_pkg::job_t      push_job,
	input  logic                q_full,
	input  srfr_pkg::busy_clr_t busy_clr
);
	import srfr_pkg::*;

	localparam logic [1:0] F_HUNT = 2'd0;
	localparam logic [1:0] F_HDR1 = 2'd1;
	localparam logic [1:0] F_RECV = 2'd2;

	logic [1:0]       state_q;
	logic [IDX_W-1:0] idx_q;
	logic [7:0]       len_q;
	logic [7:0]       sum_q;
	logic             bank_q;
	logic [1:0]       busy_q;

	logic acc, recv, is_len, len_bad, is_end, csum_ok;

	// A bank still being emitted cannot take new bytes.
	assign in_ready = !q_full && !busy_q[bank_q];
	assign acc      = in_valid && in_ready;
	assign recv     = acc && (state_q == F_RECV);
	assign is_len   = (idx_q == IDX_W'(1));
	assign len_bad  = (rx_byte < MIN_LEN) || (rx_byte > 8'(MAX_LEN));
	assign is_end   = (idx_q >= IDX_W'(2)) && (8'(idx_q) == len_q);
	assign csum_ok  = (~sum_q == rx_byte);

	always_comb begin
		mem_wr.en   = recv;
		mem_wr.addr = mem_addr(bank_q, idx_q);
		mem_wr.data = rx_byte;

		push              = recv && ((is_len && len_bad) || is_end);
		push_job.bank     = bank_q;
		push_job.last_idx = idx_q;
		if (is_len) begin
			push_job.status = ST_LEN;
		end else if (csum_ok) begin
			push_job.status = ST_OK;
		end else begin
			push_job.status = ST_CSUM;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_HUNT;
			idx_q   <= '0;
			len_q   <= '0;
			sum_q   <= '0;
			bank_q  <= 1'b0;
		end else if (acc) begin
			unique case (state_q)
				F_HUNT: begin
					if (rx_byte == HDR_BYTE) begin
						state_q <= F_HDR1;
					end
				end
				F_HDR1: begin
					state_q <= (rx_byte == HDR_BYTE) ? F_RECV : F_HUNT;
					idx_q   <= '0;
					sum_q   <= '0;
				end
				F_RECV: begin
					if (is_len) begin
						len_q <= rx_byte;
					end
					if (push) begin
						state_q <= F_HUNT;
						sum_q   <= '0;
						if (push_job.status == ST_OK) begin
							bank_q <= !bank_q;
						end
					end else begin
						sum_q <= sum_q + rx_byte;
						idx_q <= idx_q + 1'b1;
					end
				end
				default: begin
					state_q <= F_HUNT;
					sum_q   <= '0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= '0;
		end else begin
			for (int b = 0; b < 2; b++) begin
				if (push && push_job.status == ST_OK && bank_q == 1'(b)) begin
					busy_q[b] <= 1'b1;
				end else if (busy_clr.en && busy_clr.bank == 1'(b)) begin
					busy_q[b] <= 1'b0;
				end
			end
		end
	end
endmodule

>>> rtl/srfr_back.sv
// Emit back end: pops jobs and plays out stored frames or error results
// through a registered output slot. Depends on srfr_pkg.
`timescale 1ns / 1ps
module srfr_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        job_valid,
	input  srfr_pkg::job_t              job,
	output logic                        pop,
	output logic                        rd_en,
	output logic [srfr_pkg::ADDR_W-1:0] rd_addr,
	input  logic [7:0]                  rd_data,
	output srfr_pkg::busy_clr_t         busy_clr,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [7:0]                  frame_byte,
	output logic [1:0]                  status,
	output logic                        last
);
	import srfr_pkg::*;

	localparam logic [1:0] B_IDLE = 2'd0;
	localparam logic [1:0] B_ERR  = 2'd1;
	localparam logic [1:0] B_DATA = 2'd2;

	logic [1:0]       state_q;
	job_t             job_q;
	logic [IDX_W-1:0] k_q;
	logic             ov_q;
	logic [7:0]       fb_q;
	logic [1:0]       st_q;
	logic             last_q;

	logic slot_free, at_end, load;

	assign slot_free = !ov_q || out_ready;
	assign at_end    = (k_q == job_q.last_idx);
	assign load      = slot_free && ((state_q == B_ERR) || (state_q == B_DATA));
	assign pop       = (state_q == B_IDLE) && job_valid;

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = mem_addr(job.bank, '0);
		if (pop && job.status == ST_OK) begin
			rd_en = 1'b1;
		end else if (state_q == B_DATA && slot_free && !at_end) begin
			rd_en   = 1'b1;
			rd_addr = mem_addr(job_q.bank, k_q + 1'b1);
		end
		busy_clr.en   = (state_q == B_DATA) && slot_free && at_end;
		busy_clr.bank = job_q.bank;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			k_q     <= '0;
			ov_q    <= 1'b0;
		end else begin
			if (load) begin
				ov_q <= 1'b1;
			end else if (out_ready) begin
				ov_q <= 1'b0;
			end
			unique case (state_q)
				B_IDLE: begin
					if (pop) begin
						k_q     <= '0;
						state_q <= (job.status == ST_OK) ? B_DATA : B_ERR;
					end
				end
				B_ERR: begin
					if (slot_free) begin
						state_q <= B_IDLE;
					end
				end
				B_DATA: begin
					if (slot_free) begin
						if (at_end) begin
							state_q <= B_IDLE;
						end else begin
							k_q <= k_q + 1'b1;
						end
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			job_q <= job;
		end
		if (load) begin
			if (state_q == B_DATA) begin
				fb_q   <= rd_data;
				st_q   <= ST_OK;
				last_q <= at_end;
			end else begin
				fb_q   <= '0;
				st_q   <= job_q.status;
				last_q <= 1'b1;
			end
		end
	end

	assign out_valid  = ov_q;
	assign frame_byte = fb_q;
	assign status     = st_q;
	assign last       = last_q;
endmodule

>>> rtl/servo_response_frame_receiver_top.sv
// Top level of the servo response frame receiver.
// Instantiates srfr_front, srfr_fifo, srfr_buf and srfr_back; uses srfr_pkg.
//
// Input channel (in_valid/in_ready, rx_byte) takes one serial byte per
// transaction. After two 0x55 bytes, id, length, command, parameters and
// checksum are stored. Output channel (out_valid/out_ready) carries
// frame_byte, status and last.
// A good frame plays out as length+1 transactions, status 0, last on the
// checksum byte. A checksum mismatch (status 1) or a length byte below 2
// or above MAX_LEN (status 2) gives a single transaction with frame_byte 0
// and last set; the receiver then hunts for a header again.
// Throughput: one input byte per cycle while not stalled. The first byte of
// a frame passes through the job queue and one registered memory read into
// the output slot that drives out_valid; further bytes follow one per cycle
// while out_ready stays high, each through the single read port of the frame
// store. An error result goes via the queue and the error state to the slot.
// The store has two banks and the job queue two entries, so input keeps
// flowing while a frame drains; in_ready drops when the queue is full or
// the next bank is still being played out. A stalled receiver holds the
// output slot and backs up into the queue, then into the input.
// Reset clears the hunt state, the queue and the output slot.
`timescale 1ns / 1ps
module servo_response_frame_receiver_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] frame_byte,
	output logic [1:0] status,
	output logic       last
);
	import srfr_pkg::*;

	mem_wr_t           mem_wr;
	logic              push, q_full, pop, head_valid, rd_en;
	job_t              push_job, head_job;
	busy_clr_t         busy_clr;
	logic [ADDR_W-1:0] rd_addr;
	logic [7:0]        rd_data;

	srfr_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.rx_byte  (rx_byte),
		.mem_wr   (mem_wr),
		.push     (push),
		.push_job (push_job),
		.q_full   (q_full),
		.busy_clr (busy_clr)
	);

	srfr_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_job   (push_job),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_job   (head_job)
	);

	srfr_buf u_buf (
		.clk     (clk),
		.wr      (mem_wr),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	srfr_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.job_valid  (head_valid),
		.job        (head_job),
		.pop        (pop),
		.rd_en      (rd_en),
		.rd_addr    (rd_addr),
		.rd_data    (rd_data),
		.busy_clr   (busy_clr),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.frame_byte (frame_byte),
		.status     (status),
		.last       (last)
	);
endmodule

>>> rtl/srfr_chk.sv
// Port-level checker for the servo response frame receiver, bound to the
// top level. Depends on srfr_pkg.
`timescale 1ns / 1ps
module srfr_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic [7:0] rx_byte,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] frame_byte,
	input logic [1:0] status,
	input logic       last
);
	import srfr_pkg::*;

	// stalled input transaction holds its byte
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(rx_byte))
		else $error("input changed while stalled");

	// stalled output transaction holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(frame_byte)
			&& $stable(status) && $stable(last))
		else $error("output changed while stalled");

	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> last && frame_byte == 8'd0)
		else $error("error result without last or with nonzero byte");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status == ST_OK || status == ST_CSUM || status == ST_LEN)
		else $error("unknown status code");

	// no result is valid right after reset is sampled
	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |=> !out_valid)
		else $error("output valid right after reset");
endmodule

bind servo_response_frame_receiver_top srfr_chk u_chk (.*);
